@@ rtl/tle_pkg.sv @@
// Package for the telnet line editor: byte codes, command and action codes,
// line and queue sizes, and the command type passed from front to back.
// No dependencies.
package tle_pkg;

    localparam int LINE_MAX    = 32;
    localparam int LEN_W       = $clog2(LINE_MAX + 1);
    localparam int IDX_W       = $clog2(LINE_MAX);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_MAX     = 63;

    localparam logic [7:0] B_IAC      = 8'hFF;
    localparam logic [7:0] B_WILL     = 8'hFB;
    localparam logic [7:0] B_DONT     = 8'hFE;
    localparam logic [7:0] B_ESC      = 8'h1B;
    localparam logic [7:0] B_DEL      = 8'h7F;
    localparam logic [7:0] B_BS       = 8'h08;
    localparam logic [7:0] B_ETX      = 8'h03;
    localparam logic [7:0] B_NAK      = 8'h15;
    localparam logic [7:0] B_SPACE    = 8'h20;
    localparam logic [7:0] B_CR       = 8'h0D;
    localparam logic [7:0] B_LF       = 8'h0A;
    localparam logic [7:0] B_LBRACKET = 8'h5B;

    localparam logic [2:0] ACT_ECHO       = 3'd0;
    localparam logic [2:0] ACT_ERASE_ONE  = 3'd1;
    localparam logic [2:0] ACT_ERASE_LINE = 3'd2;
    localparam logic [2:0] ACT_CANCEL     = 3'd3;
    localparam logic [2:0] ACT_EMPTY      = 3'd4;
    localparam logic [2:0] ACT_LINE_CHAR  = 3'd5;

    localparam logic [2:0] OP_PUT        = 3'd0;
    localparam logic [2:0] OP_ERASE_ONE  = 3'd1;
    localparam logic [2:0] OP_ERASE_LINE = 3'd2;
    localparam logic [2:0] OP_CANCEL     = 3'd3;
    localparam logic [2:0] OP_EMPTY      = 3'd4;
    localparam logic [2:0] OP_LINE       = 3'd5;

    typedef logic [LEN_W-1:0] t_len;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        t_len       len;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    function automatic logic [5:0] f_sat_count(t_len n);
        if (int'(n) > CNT_MAX) begin
            return 6'(CNT_MAX);
        end
        return 6'(n);
    endfunction

endpackage

@@ rtl/tle_if.sv @@
// Channel interfaces of the telnet line editor: received byte in, result out.
// No dependencies.
interface tle_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tle_tx_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] data_byte;
    logic [5:0] erase_count;
    logic       last;

    modport source (output valid, output action, output data_byte,
                    output erase_count, output last, input ready);
    modport sink   (input valid, input action, input data_byte,
                    input erase_count, input last, output ready);
endinterface

@@ rtl/tle_front.sv @@
// Front end: accepts received bytes, strips telnet and escape sequences,
// folds CR LF, tracks the line length and issues edit commands.
// Depends on tle_pkg and tle_if.
module tle_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tle_rx_if.sink        i_rx,
    input  logic          i_full,
    output tle_pkg::t_push o_push
);
    import tle_pkg::*;

    localparam logic [1:0] TEL_IDLE = 2'd0;
    localparam logic [1:0] TEL_CMD  = 2'd1;
    localparam logic [1:0] TEL_OPT  = 2'd2;

    localparam logic [1:0] ESC_IDLE    = 2'd0;
    localparam logic [1:0] ESC_SEEN    = 2'd1;
    localparam logic [1:0] ESC_BRACKET = 2'd2;

    logic [1:0] r_tel, n_tel;
    logic [1:0] r_esc, n_esc;
    logic       r_prev_cr, n_prev_cr;
    t_len       r_len, n_len;
    logic       w_acc;
    logic [7:0] w_b;

    assign i_rx.ready = !i_full;
    assign w_acc      = i_rx.valid && !i_full;
    assign w_b        = i_rx.rx_byte;

    always_comb begin
        n_tel         = r_tel;
        n_esc         = r_esc;
        n_prev_cr     = r_prev_cr;
        n_len         = r_len;
        o_push.valid  = 1'b0;
        o_push.cmd.op = OP_PUT;
        o_push.cmd.data = w_b;
        o_push.cmd.len  = r_len;
        if (w_acc) begin
            if (r_tel == TEL_CMD) begin
                n_tel = (w_b >= B_WILL && w_b <= B_DONT) ? TEL_OPT : TEL_IDLE;
            end else if (r_tel != TEL_IDLE) begin
                n_tel = TEL_IDLE;
            end else if (w_b == B_IAC) begin
                n_tel = TEL_CMD;
            end else if (r_esc == ESC_SEEN) begin
                n_esc = (w_b == B_LBRACKET) ? ESC_BRACKET : ESC_IDLE;
            end else if (r_esc != ESC_IDLE) begin
                n_esc = ESC_IDLE;
            end else if (w_b == B_ESC) begin
                n_esc = ESC_SEEN;
            end else if (w_b == B_LF && r_prev_cr) begin
                n_prev_cr = 1'b0;
            end else begin
                n_prev_cr = (w_b == B_CR);
                if (w_b == B_CR || w_b == B_LF) begin
                    o_push.valid  = 1'b1;
                    o_push.cmd.op = (r_len == '0) ? OP_EMPTY : OP_LINE;
                    n_len         = '0;
                end else if (w_b == B_DEL || w_b == B_BS) begin
                    if (r_len != '0) begin
                        o_push.valid  = 1'b1;
                        o_push.cmd.op = OP_ERASE_ONE;
                        n_len         = r_len - t_len'(1);
                    end
                end else if (w_b == B_ETX) begin
                    o_push.valid  = 1'b1;
                    o_push.cmd.op = OP_CANCEL;
                    n_len         = '0;
                end else if (w_b == B_NAK) begin
                    o_push.valid  = 1'b1;
                    o_push.cmd.op = OP_ERASE_LINE;
                    n_len         = '0;
                end else if (w_b >= B_SPACE && w_b < B_DEL) begin
                    if (r_len < t_len'(LINE_MAX)) begin
                        o_push.valid  = 1'b1;
                        o_push.cmd.op = OP_PUT;
                        n_len         = r_len + t_len'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tel     <= TEL_IDLE;
            r_esc     <= ESC_IDLE;
            r_prev_cr <= 1'b0;
            r_len     <= '0;
        end else begin
            r_tel     <= n_tel;
            r_esc     <= n_esc;
            r_prev_cr <= n_prev_cr;
            r_len     <= n_len;
        end
    end

endmodule

@@ rtl/tle_queue.sv @@
// Command queue between the front and back ends of the line editor.
// Depends on tle_pkg.
module tle_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tle_pkg::t_push i_push,
    output logic           o_full,
    output logic           o_head_valid,
    output tle_pkg::t_cmd  o_head,
    input  logic           i_pop
);
    import tle_pkg::*;

    t_cmd              r_buf [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push, w_pop;

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_buf[r_rd_ptr];
    assign w_push       = i_push.valid && !o_full;
    assign w_pop        = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr_ptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/tle_back.sv @@
// Back end: executes edit commands, holds the line store and drives the
// result channel through an output register.
// Depends on tle_pkg and tle_if.
module tle_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  tle_pkg::t_cmd i_head,
    output logic          o_pop,
    tle_tx_if.source      o_tx
);
    import tle_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [7:0] r_mem [LINE_MAX];
    logic [7:0] r_rd_data;
    logic [1:0] r_state, n_state;
    t_len       r_idx, n_idx;
    t_len       r_n, n_n;
    logic       r_ov, n_ov;
    logic [2:0] r_act, n_act;
    logic [7:0] r_dat, n_dat;
    logic [5:0] r_cnt, n_cnt;
    logic       r_last, n_last;
    logic       w_out_free;
    logic       w_wr_en;

    assign w_out_free     = !r_ov || o_tx.ready;
    assign o_tx.valid     = r_ov;
    assign o_tx.action    = r_act;
    assign o_tx.data_byte = r_dat;
    assign o_tx.erase_count = r_cnt;
    assign o_tx.last      = r_last;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_n     = r_n;
        n_ov    = r_ov && !o_tx.ready;
        n_act   = r_act;
        n_dat   = r_dat;
        n_cnt   = r_cnt;
        n_last  = r_last;
        o_pop   = 1'b0;
        w_wr_en = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_head_valid && w_out_free) begin
                    o_pop  = 1'b1;
                    n_ov   = 1'b1;
                    n_dat  = 8'h00;
                    n_cnt  = 6'd0;
                    n_last = 1'b1;
                    case (i_head.op)
                        OP_PUT: begin
                            w_wr_en = 1'b1;
                            n_act   = ACT_ECHO;
                            n_dat   = i_head.data;
                        end
                        OP_ERASE_ONE:  n_act = ACT_ERASE_ONE;
                        OP_ERASE_LINE: begin
                            n_act = ACT_ERASE_LINE;
                            n_cnt = f_sat_count(i_head.len);
                        end
                        OP_CANCEL:     n_act = ACT_CANCEL;
                        OP_LINE: begin
                            n_ov    = 1'b0;
                            n_idx   = '0;
                            n_n     = i_head.len;
                            n_state = ST_RD;
                        end
                        default:       n_act = ACT_EMPTY;
                    endcase
                end
            end
            ST_RD: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_act   = ACT_LINE_CHAR;
                    n_dat   = r_rd_data;
                    n_cnt   = 6'd0;
                    n_last  = (r_idx + t_len'(1) == r_n);
                    n_idx   = r_idx + t_len'(1);
                    n_state = n_last ? ST_IDLE : ST_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[i_head.len[IDX_W-1:0]] <= i_head.data;
        end
        r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_n    <= n_n;
        r_act  <= n_act;
        r_dat  <= n_dat;
        r_cnt  <= n_cnt;
        r_last <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

endmodule

@@ rtl/telnet_line_editor_top.sv @@
// Top level of the telnet line editor: front end, command queue, back end.
// Depends on tle_pkg, tle_if, tle_front, tle_queue and tle_back.
//
//   channel  dir  payload                                   accepted when
//   i_rx     in   rx_byte                                   valid && ready
//   o_tx     out  action, data_byte, erase_count, last      valid && ready
//
// A byte is taken every cycle while the four-entry command queue has room.
// Echo, erase, cancel and empty-line results come from the idle state; a
// line alternates read and output states per character: the line store is
// read through a register. Reset is synchronous and clears control state;
// the store is not cleared. A stalled result holds in the output register.
module telnet_line_editor_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tle_rx_if.sink   i_rx,
    tle_tx_if.source o_tx
);
    import tle_pkg::*;

    t_push w_push;
    t_cmd  w_head;
    logic  w_full;
    logic  w_head_valid;
    logic  w_pop;

    tle_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_full  (w_full),
        .o_push  (w_push)
    );

    tle_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_full       (w_full),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    tle_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_tx         (o_tx)
    );

endmodule
